// File: src/index_free_stack_allocator_defines.svh
// Assertion macros for the verification file of the index allocator.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef INDEX_FREE_STACK_ALLOCATOR_DEFINES_SVH
`define INDEX_FREE_STACK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IFSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define IFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ifsa_pkg.sv
// Shared types and constants of the index allocator: word layouts,
// command and status codes, controller interface structs. Depends on nothing.
package ifsa_pkg;

  localparam int ENTRIES_DEFAULT = 1024;
  localparam int SLOT_W          = 10;
  localparam int STATUS_W        = 2;
  localparam int CNT_W           = 11;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_index;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    free_slots;
    logic                slot_was_occupied;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the request word and launch the memory reads
    logic commit;   // apply the update and load the result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage

// File: src/ifsa_ctrl.sv
// Controller of the index allocator: a two-state sequencer that gates
// request acceptance and commit. Depends on ifsa_pkg.
module ifsa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  rsp_stall,
  input  ifsa_pkg::dp_status_t  status,
  output ifsa_pkg::dp_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.capture = (state == S_IDLE) && req_valid;
    cmd.commit  = (state == S_EXEC) && (!status.out_valid || !rsp_stall);
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/ifsa_dpath.sv
// Datapath of the index allocator: free-index stack memory, occupancy memory,
// count and low-water mark, result register. Depends on ifsa_pkg.
module ifsa_dpath #(
  parameter int ENTRIES = ifsa_pkg::ENTRIES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ifsa_pkg::req_t        req,
  input  logic                  rsp_stall,
  input  ifsa_pkg::dp_cmd_t     cmd,
  output ifsa_pkg::dp_status_t  status,
  output logic                  rsp_valid,
  output ifsa_pkg::rsp_t        rsp
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > ifsa_pkg::CNT_W) ? CW : ifsa_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  logic [IW-1:0] stack_mem [ENTRIES];
  logic          occ_mem   [ENTRIES];

  logic [CW-1:0]  count;
  logic [CW-1:0]  low_mark;
  ifsa_pkg::req_t req_q;
  logic [IW-1:0]  stack_rd;
  logic           occ_rd;

  logic [CW-1:0] count_next;
  logic [CW-1:0] low_mark_next;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] pos;
  logic [XW-1:0] idx_in_x;
  logic [IW-1:0] occ_raddr;
  logic [XW-1:0] idx_x;
  logic [IW-1:0] idx_a;
  logic          in_range;
  logic          below_low;
  logic          occ_cur;
  logic [IW-1:0] top;
  logic [IW-1:0] granted;
  logic [ifsa_pkg::STATUS_W-1:0] st;
  logic          stack_we;
  logic          occ_we;
  logic [IW-1:0] occ_waddr;
  logic          occ_wdata;
  logic [XW-1:0] granted_x;
  logic [XW-1:0] cnt_x;

  assign cnt_m1    = count - CW'(1);
  assign pos       = cnt_m1[IW-1:0];
  assign idx_in_x  = XW'(req.slot_index);
  assign occ_raddr = idx_in_x[IW-1:0];

  // Stack positions below the low-water mark were never written and still
  // hold their own position; slots below it were never handed out.
  assign idx_x     = XW'(req_q.slot_index);
  assign idx_a     = idx_x[IW-1:0];
  assign in_range  = idx_x < XW'(ENTRIES);
  assign below_low = idx_x < XW'(low_mark);
  assign occ_cur   = in_range && !below_low && occ_rd;
  assign top       = (count == low_mark) ? pos : stack_rd;

  always_comb begin
    st            = ifsa_pkg::ST_OK;
    granted       = '0;
    count_next    = count;
    low_mark_next = low_mark;
    stack_we      = 1'b0;
    occ_we        = 1'b0;
    occ_waddr     = idx_a;
    occ_wdata     = 1'b0;
    if (req_q.command == ifsa_pkg::CMD_ALLOC) begin
      if (count == '0) begin
        st = ifsa_pkg::ST_EMPTY;
      end else begin
        granted    = top;
        count_next = cnt_m1;
        occ_we     = 1'b1;
        occ_waddr  = top;
        occ_wdata  = 1'b1;
        if (cnt_m1 < low_mark) begin
          low_mark_next = cnt_m1;
        end
      end
    end else if (!in_range) begin
      st = ifsa_pkg::ST_RANGE;
    end else if (!occ_cur || (count >= FULL)) begin
      st = ifsa_pkg::ST_NOT_ALLOC;
    end else begin
      stack_we   = 1'b1;
      count_next = count + CW'(1);
      occ_we     = 1'b1;
    end
  end

  assign granted_x = XW'(granted);
  assign cnt_x     = XW'(count_next);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stack_rd <= stack_mem[pos];
    end
    if (cmd.commit && stack_we) begin
      stack_mem[count[IW-1:0]] <= idx_a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      occ_rd <= occ_mem[occ_raddr];
    end
    if (cmd.commit && occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.commit) begin
      rsp.granted_index     <= granted_x[ifsa_pkg::SLOT_W-1:0];
      rsp.status            <= st;
      rsp.free_slots        <= cnt_x[ifsa_pkg::CNT_W-1:0];
      rsp.slot_was_occupied <= occ_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= FULL;
      low_mark  <= FULL;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count    <= count_next;
        low_mark <= low_mark_next;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign status.out_valid = rsp_valid;

endmodule

// File: src/index_free_stack_allocator.sv
// Index allocator built on a free-index stack, top level.
// Depends on ifsa_pkg, ifsa_ctrl and ifsa_dpath.
//
// Usage: a request word on req (command, slot_index) is taken when req_valid
// is high and req_stall is low. An allocate pops the top free index; a free
// pushes slot_index back. Each request produces exactly one result word on
// rsp (granted_index, status, free_slots, slot_was_occupied), offered with
// rsp_valid and taken when rsp_stall is low.
// A request is taken in S_IDLE, which reads the stack memory at the top and
// the occupancy memory at slot_index through their registered read ports.
// S_EXEC then applies the update and loads the result register, which raises
// rsp_valid; no new request is taken before that commit. The next request is
// taken right after it, even while the result still waits in its register.
// When the receiver stalls, the result holds in its register; a following
// request is accepted and read, then waits for commit until that register frees.
// Reset (rst, synchronous) sets the free count and a low-water mark to
// ENTRIES. No clearing pass runs: stack positions and slots below the mark
// read as their reset values, so requests are taken right after reset.
module index_free_stack_allocator #(
  parameter int ENTRIES = ifsa_pkg::ENTRIES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ifsa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ifsa_pkg::rsp_t rsp
);

  ifsa_pkg::dp_cmd_t    cmd;
  ifsa_pkg::dp_status_t status;

  // The sequencer decides when a request is taken and when it commits.
  ifsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the stack, the occupancy bits and the result register.
  ifsa_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// File: src/ifsa_checker.sv
// Port-level checks of the index allocator and their bind to the top level.
// Depends on ifsa_pkg and index_free_stack_allocator_defines.svh.
`include "index_free_stack_allocator_defines.svh"

module ifsa_checker #(
  parameter int ENTRIES = ifsa_pkg::ENTRIES_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input ifsa_pkg::rsp_t rsp
);

  logic req_take;

  assign req_take = req_valid && !req_stall;

  // A stalled result word holds.
  `IFSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // A request is worked on alone, so the next cycle refuses another one.
  `IFSA_ASSERT_NEXT(a_one_at_a_time, req_take, req_stall)

  // An empty pool grants nothing and reports no free slots.
  `IFSA_ASSERT_NOW(a_empty_result,
    rsp_valid && (rsp.status == ifsa_pkg::ST_EMPTY),
    (rsp.granted_index == '0) && (rsp.free_slots == '0))

  // An out-of-range slot is never reported occupied, and a free grants nothing.
  `IFSA_ASSERT_NOW(a_range_result,
    rsp_valid && (rsp.status == ifsa_pkg::ST_RANGE),
    !rsp.slot_was_occupied && (rsp.granted_index == '0))

  // A granted index always names a slot of the pool.
  `IFSA_ASSERT_NOW(a_grant_in_pool, rsp_valid, int'(rsp.granted_index) < ENTRIES)

endmodule

bind index_free_stack_allocator ifsa_checker #(
  .ENTRIES (ENTRIES)
) u_ifsa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
